// File: design/utf8_encoder_with_byte_budget_defines.svh
// ----------------------------------------------------------------------------
// utf8 encoder assertion macros
// shared assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef UTF8_ENCODER_WITH_BYTE_BUDGET_DEFINES_SVH
`define UTF8_ENCODER_WITH_BYTE_BUDGET_DEFINES_SVH

// same-cycle implication, held off during reset
`define UTF8E_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define UTF8E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/utf8e_pkg.sv
// ----------------------------------------------------------------------------
// utf8e_pkg
// types, code point limits and byte formats for the utf8 encoder
// ----------------------------------------------------------------------------
package utf8e_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [20:0] t_code_point;
    typedef logic [15:0] t_count;
    // encoded length minus one: 0 for one byte, 3 for four bytes
    typedef logic [1:0]  t_len;

    // configuration register indexes
    localparam logic CFG_BUDGET_ENABLE = 1'b0;
    localparam logic CFG_BYTE_BUDGET   = 1'b1;

    // code point boundaries
    localparam t_code_point CP_LIMIT = 21'd1114112;
    localparam t_code_point CP_FOUR  = 21'd65536;
    localparam t_code_point CP_THREE = 21'd2048;
    localparam t_code_point CP_TWO   = 21'd128;

    // length codes
    localparam t_len LEN_ONE   = 2'd0;
    localparam t_len LEN_TWO   = 2'd1;
    localparam t_len LEN_THREE = 2'd2;
    localparam t_len LEN_FOUR  = 2'd3;

    // lead and continuation prefixes
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    localparam t_count COUNT_MAX = 16'hFFFF;

endpackage

// File: design/utf8_encoder_with_byte_budget.sv
// ----------------------------------------------------------------------------
// utf8_encoder_with_byte_budget
// utf8 encoder with an optional per-string output byte budget
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : i_in_valid / o_in_stall, one code point per transaction,
//                    with i_start_of_string marking the first item of a string
//   output channel : o_out_valid / i_out_stall, one encoded byte per
//                    transaction, o_last_byte high on the final byte of a char
//   config port    : i_cfg_we, i_cfg_index, i_cfg_wdata; write only while idle
// Flow: a code point accepted into the input register moves into the result
//   register once the result register is free; its first byte is offered there.
//   An item holds the result register until its bytes (1 to 4) are taken;
//   the output port gives one byte per cycle while i_out_stall is low, and
//   the next item is already held in the input register meanwhile. Items with
//   no bytes (terminator, invalid, over budget, stopped) load no result.
// Reset: clears both valids, the byte count, the stop flag and the config.
// Stall: while i_out_stall is high the current byte holds; once the input
//   register is also full, o_in_stall rises until the last byte is taken.
// ----------------------------------------------------------------------------
`include "utf8_encoder_with_byte_budget_defines.svh"

module utf8_encoder_with_byte_budget (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [15:0]            i_cfg_wdata,
    // code point input
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  utf8e_pkg::t_code_point i_code_point,
    input  logic                   i_start_of_string,
    // byte output
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output utf8e_pkg::t_byte       o_out_byte,
    output logic                   o_last_byte
);

    // configuration registers
    logic                  r_budget_enable;
    utf8e_pkg::t_count     r_byte_budget;

    // string state
    utf8e_pkg::t_count     r_bytes_used;
    logic                  r_stopped;
    utf8e_pkg::t_count     n_bytes_used;
    logic                  n_stopped;

    // input register
    logic                  r_in_vld;
    utf8e_pkg::t_code_point r_in_cp;
    logic                  r_in_sos;

    // result register
    logic                  r_res_vld;
    utf8e_pkg::t_byte      r_res_byte [4];
    utf8e_pkg::t_len       r_res_cnt;

    // handshake terms
    logic                  in_take;
    logic                  out_take;
    logic                  res_free;
    logic                  in_move;

    // encode terms
    logic                  eff_stopped;
    utf8e_pkg::t_count     eff_used;
    utf8e_pkg::t_len       len;
    logic [16:0]           sum;
    logic                  produce;
    utf8e_pkg::t_byte      enc [4];

    // handshake
    assign out_take   = r_res_vld && !i_out_stall;
    assign res_free   = !r_res_vld || (out_take && (r_res_cnt == utf8e_pkg::LEN_ONE));
    assign in_move    = r_in_vld && res_free;
    assign o_in_stall = r_in_vld && !res_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_res_vld;
    assign o_out_byte  = r_res_byte[0];
    assign o_last_byte = (r_res_cnt == utf8e_pkg::LEN_ONE);

    // length, budget check and state update
    always_comb begin
        eff_stopped = r_in_sos ? 1'b0 : r_stopped;
        eff_used    = r_in_sos ? '0 : r_bytes_used;

        priority if (r_in_cp < utf8e_pkg::CP_TWO) begin
            len = utf8e_pkg::LEN_ONE;
        end else if (r_in_cp < utf8e_pkg::CP_THREE) begin
            len = utf8e_pkg::LEN_TWO;
        end else if (r_in_cp < utf8e_pkg::CP_FOUR) begin
            len = utf8e_pkg::LEN_THREE;
        end else begin
            len = utf8e_pkg::LEN_FOUR;
        end

        sum = {1'b0, eff_used} + {15'd0, len} + 17'd1;

        n_stopped    = eff_stopped;
        n_bytes_used = eff_used;
        produce      = 1'b0;
        if (!eff_stopped) begin
            priority if ((r_in_cp == '0) || (r_in_cp >= utf8e_pkg::CP_LIMIT)) begin
                n_stopped = 1'b1;
            end else if (r_budget_enable && (sum > {1'b0, r_byte_budget})) begin
                n_stopped = 1'b1;
            end else begin
                produce      = 1'b1;
                n_bytes_used = sum[16] ? utf8e_pkg::COUNT_MAX : sum[15:0];
            end
        end
    end

    // byte formatting, first byte in slot 0
    always_comb begin
        enc[0] = '0;
        enc[1] = '0;
        enc[2] = '0;
        enc[3] = '0;
        unique case (len)
            utf8e_pkg::LEN_ONE: begin
                enc[0] = r_in_cp[7:0];
            end
            utf8e_pkg::LEN_TWO: begin
                enc[0] = {utf8e_pkg::LEAD2_TAG, r_in_cp[10:6]};
                enc[1] = {utf8e_pkg::CONT_TAG, r_in_cp[5:0]};
            end
            utf8e_pkg::LEN_THREE: begin
                enc[0] = {utf8e_pkg::LEAD3_TAG, r_in_cp[15:12]};
                enc[1] = {utf8e_pkg::CONT_TAG, r_in_cp[11:6]};
                enc[2] = {utf8e_pkg::CONT_TAG, r_in_cp[5:0]};
            end
            utf8e_pkg::LEN_FOUR: begin
                enc[0] = {utf8e_pkg::LEAD4_TAG, r_in_cp[20:18]};
                enc[1] = {utf8e_pkg::CONT_TAG, r_in_cp[17:12]};
                enc[2] = {utf8e_pkg::CONT_TAG, r_in_cp[11:6]};
                enc[3] = {utf8e_pkg::CONT_TAG, r_in_cp[5:0]};
            end
            default: begin
                enc[0] = '0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget_enable <= 1'b0;
            r_byte_budget   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                utf8e_pkg::CFG_BUDGET_ENABLE: r_budget_enable <= i_cfg_wdata[0];
                utf8e_pkg::CFG_BYTE_BUDGET:   r_byte_budget   <= i_cfg_wdata;
                default:                      r_budget_enable <= r_budget_enable;
            endcase
        end
    end

    // string state, updated as an item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_used <= '0;
            r_stopped    <= 1'b0;
        end else if (in_move) begin
            r_bytes_used <= n_bytes_used;
            r_stopped    <= n_stopped;
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (in_move) begin
            r_in_vld <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cp  <= i_code_point;
            r_in_sos <= i_start_of_string;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (in_move) begin
            r_res_vld <= produce;
        end else if (res_free) begin
            r_res_vld <= 1'b0;
        end
    end

    // result payload: load on move, shift one byte out per transaction
    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_res_byte <= enc;
            r_res_cnt  <= len;
        end else if (out_take && (r_res_cnt != utf8e_pkg::LEN_ONE)) begin
            r_res_byte[0] <= r_res_byte[1];
            r_res_byte[1] <= r_res_byte[2];
            r_res_byte[2] <= r_res_byte[3];
            r_res_byte[3] <= '0;
            r_res_cnt     <= r_res_cnt - 2'd1;
        end
    end

    // checks
    `UTF8E_ASSERT_NEXT(a_mid_char_continues,
        out_take && !o_last_byte, o_out_valid,
        "character cut short after a non-final byte")
    `UTF8E_ASSERT_NEXT(a_stopped_gives_nothing,
        in_move && r_stopped && !r_in_sos, !r_res_vld,
        "stopped string produced output")
    `UTF8E_ASSERT_NEXT(a_stopped_count_holds,
        r_stopped && !(in_move && r_in_sos), $stable(r_bytes_used),
        "byte count changed on a stopped string")

endmodule
